@@ rtl/qsr_pkg.sv @@
// Shared types and constants for the quaternion sandwich rotation core.
// Holds the input and output word structs and the offset register map.
// No dependencies.
`default_nettype none

package qsr_pkg;

  // Width of one input quaternion component and of one offset register.
  localparam int unsigned COMP_WIDTH = 16;
  // Default number of fraction bits of the input components.
  localparam int unsigned FRAC_BITS = 14;
  // Width of one rounded output component.
  localparam int unsigned OUT_WIDTH = 24;
  // Width of the rounding arithmetic; wider sums wrap to it.
  localparam int unsigned RND_WIDTH = 64;
  // Width of the offset register index.
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // Offset register map.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_OFFSET_W = 2'd0,
    REG_OFFSET_X = 2'd1,
    REG_OFFSET_Y = 2'd2,
    REG_OFFSET_Z = 2'd3
  } cfg_reg_e;

  // Offset register reset values (1.0 + 0i + 0j + 0k in Q2.14).
  localparam logic signed [COMP_WIDTH-1:0] OFFSET_W_RESET = 16'sd16384;
  localparam logic signed [COMP_WIDTH-1:0] OFFSET_X_RESET = 16'sd0;
  localparam logic signed [COMP_WIDTH-1:0] OFFSET_Y_RESET = 16'sd0;
  localparam logic signed [COMP_WIDTH-1:0] OFFSET_Z_RESET = 16'sd0;

  // Input word: sensor orientation quaternion.
  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] orient_w;
    logic signed [COMP_WIDTH-1:0] orient_x;
    logic signed [COMP_WIDTH-1:0] orient_y;
    logic signed [COMP_WIDTH-1:0] orient_z;
  } orient_t;

  // Output word: rotated pose quaternion.
  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] pose_w;
    logic signed [OUT_WIDTH-1:0] pose_x;
    logic signed [OUT_WIDTH-1:0] pose_y;
    logic signed [OUT_WIDTH-1:0] pose_z;
  } pose_t;

endpackage

`default_nettype wire

@@ rtl/quaternion_sandwich_rotation_core.sv @@
// Top level of the quaternion sandwich rotation core: pose = q * p * conj(q).
// Five-stage multiply/add pipeline plus the offset quaternion registers.
// Depends on qsr_pkg.
`default_nettype none

// Takes one orientation quaternion q per cycle, unless in_stall_o holds it,
// and returns q * p * conj(q), where p is the offset quaternion held in four
// registers (index 0..3 = w, x, y, z, reset to 1 + 0i + 0j + 0k). Each word
// passes through the five-stage pipeline (product, sum, product, sum, round)
// before it appears with out_valid_o, and a new word can enter while earlier
// ones are in flight. Intermediate values are exact; each output component is
// rounded to FRAC_BITS fraction bits by adding 2^(2*FRAC_BITS-1) and
// shifting right arithmetically by 2*FRAC_BITS. Stages collapse bubbles
// independently, so a stalled output only backs up the input once every
// stage holds a word. Write the offsets only while the pipeline is empty;
// the configuration port is always ready.
module quaternion_sandwich_rotation_core #(
  parameter int unsigned FRAC_BITS = qsr_pkg::FRAC_BITS
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // input words
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  qsr_pkg::orient_t                      in_data_i,
  // output words
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output qsr_pkg::pose_t                        out_data_o,
  // offset register writes
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [qsr_pkg::CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  wire [qsr_pkg::COMP_WIDTH-1:0]         cfg_data_i
);

  localparam int unsigned CW      = qsr_pkg::COMP_WIDTH;
  localparam int unsigned PW      = 2 * CW;        // q*p product
  localparam int unsigned TW      = PW + 2;        // sum of four q*p products
  localparam int unsigned QW      = TW + CW;       // t*q product
  localparam int unsigned RW      = QW + 2;        // sum of four t*q products
  localparam int unsigned RNDW    = qsr_pkg::RND_WIDTH;
  localparam int unsigned OW      = qsr_pkg::OUT_WIDTH;
  localparam int unsigned SHIFT   = 2 * FRAC_BITS;
  localparam int unsigned NSTAGE  = 5;

  localparam logic signed [RNDW-1:0] RND_HALF = RNDW'(1) << (SHIFT - 1);

  // Offset quaternion registers.
  logic signed [CW-1:0] off_q [4];

  // Per-stage valid bits and load enables.
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] en;

  // Pipeline payload.
  logic signed [CW-1:0] q1_q  [4];
  logic signed [CW-1:0] q2_q  [4];
  logic signed [PW-1:0] qp_q  [4][4];   // qp_q[a][b] = q_a * p_b
  logic signed [TW-1:0] t_q   [4];
  logic signed [QW-1:0] tq_q  [4][4];   // tq_q[a][b] = t_a * q_b
  logic signed [RW-1:0] r_q   [4];
  qsr_pkg::pose_t       out_q;

  // Rounding stage combinational values.
  logic signed [RNDW-1:0] rnd_sum [4];
  logic signed [RNDW-1:0] rnd_shf [4];

  assign cfg_ready_o = 1'b1;

  // Write offset registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= qsr_pkg::OFFSET_W_RESET;
      off_q[1] <= qsr_pkg::OFFSET_X_RESET;
      off_q[2] <= qsr_pkg::OFFSET_Y_RESET;
      off_q[3] <= qsr_pkg::OFFSET_Z_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qsr_pkg::REG_OFFSET_W: off_q[0] <= $signed(cfg_data_i);
        qsr_pkg::REG_OFFSET_X: off_q[1] <= $signed(cfg_data_i);
        qsr_pkg::REG_OFFSET_Y: off_q[2] <= $signed(cfg_data_i);
        qsr_pkg::REG_OFFSET_Z: off_q[3] <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  // Move valid bits along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: products of the sensor and offset components.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      q1_q[0] <= in_data_i.orient_w;
      q1_q[1] <= in_data_i.orient_x;
      q1_q[2] <= in_data_i.orient_y;
      q1_q[3] <= in_data_i.orient_z;
      for (int b = 0; b < 4; b++) begin
        qp_q[0][b] <= in_data_i.orient_w * off_q[b];
        qp_q[1][b] <= in_data_i.orient_x * off_q[b];
        qp_q[2][b] <= in_data_i.orient_y * off_q[b];
        qp_q[3][b] <= in_data_i.orient_z * off_q[b];
      end
    end
  end

  // Stage 2: Hamilton product t = q * p.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q2_q   <= q1_q;
      t_q[0] <= TW'(qp_q[0][0]) - TW'(qp_q[1][1]) - TW'(qp_q[2][2]) - TW'(qp_q[3][3]);
      t_q[1] <= TW'(qp_q[0][1]) + TW'(qp_q[1][0]) + TW'(qp_q[2][3]) - TW'(qp_q[3][2]);
      t_q[2] <= TW'(qp_q[0][2]) + TW'(qp_q[2][0]) + TW'(qp_q[3][1]) - TW'(qp_q[1][3]);
      t_q[3] <= TW'(qp_q[0][3]) + TW'(qp_q[3][0]) + TW'(qp_q[1][2]) - TW'(qp_q[2][1]);
    end
  end

  // Stage 3: products of t with the sensor components.
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          tq_q[a][b] <= t_q[a] * q2_q[b];
        end
      end
    end
  end

  // Stage 4: Hamilton product r = t * conj(q), conjugate signs folded in.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      r_q[0] <= RW'(tq_q[0][0]) + RW'(tq_q[1][1]) + RW'(tq_q[2][2]) + RW'(tq_q[3][3]);
      r_q[1] <= RW'(tq_q[1][0]) - RW'(tq_q[0][1]) - RW'(tq_q[2][3]) + RW'(tq_q[3][2]);
      r_q[2] <= RW'(tq_q[2][0]) - RW'(tq_q[0][2]) - RW'(tq_q[3][1]) + RW'(tq_q[1][3]);
      r_q[3] <= RW'(tq_q[3][0]) - RW'(tq_q[0][3]) - RW'(tq_q[1][2]) + RW'(tq_q[2][1]);
    end
  end

  // Round half up and drop the extra fraction bits.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd_sum[i] = RNDW'(r_q[i]) + RND_HALF;
      rnd_shf[i] = rnd_sum[i] >>> SHIFT;
    end
  end

  // Stage 5: output register.
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q.pose_w <= rnd_shf[0][OW-1:0];
      out_q.pose_x <= rnd_shf[1][OW-1:0];
      out_q.pose_y <= rnd_shf[2][OW-1:0];
      out_q.pose_z <= rnd_shf[3][OW-1:0];
    end
  end

  assign out_valid_o = vld_q[NSTAGE-1];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for quaternion_sandwich_rotation_core (pose = q * p * conj(q)).
// Drives orientation words, rewrites the offset registers between phases, and predicts each
// pose word in a scoreboard class. Depends on qsr_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qsr_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 5;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 12;
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PER_PHASE = 165;
  localparam int NUM_FIXED        = 5;
  localparam int NUM_RANDOM_SETS  = 3;
  localparam int NUM_DIRECTED     = 16;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [OUT_WIDTH-1:0]  pose_comp_t;

  // Exact 64-bit quaternion used by the predictor.
  typedef struct {
    longint w;
    longint x;
    longint y;
    longint z;
  } wide_quat_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  // Offset sets visited after the reset phase: extremes first, then pure rotations.
  localparam comp_t FIXED_OFFSETS [NUM_FIXED][4] = '{
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
    '{16'shc000, 16'sh0000, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000}
  };

  // Directed orientations: zero, units, extremes, alternating bits, rounding ties.
  localparam orient_t DIRECTED_ORIENTS [NUM_DIRECTED] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
    '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
    '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
    '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000},
    '{16'shc000, 16'sh0000, 16'sh0000, 16'sh0000},
    '{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001},
    '{16'shffff, 16'shffff, 16'shffff, 16'shffff},
    '{16'sh2d41, 16'sh2d41, 16'sh0000, 16'sh0000},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
    '{16'sh0040, 16'sh0040, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 16'shffc0, 16'sh0040}
  };

  // Predicts pose words from accepted orientations and checks them in order.
  class pose_scoreboard;
    comp_t      offset_w;
    comp_t      offset_x;
    comp_t      offset_y;
    comp_t      offset_z;
    pose_t      pending_poses [$];
    int         error_count;

    function new();
      offset_w    = OFFSET_W_RESET;
      offset_x    = OFFSET_X_RESET;
      offset_y    = OFFSET_Y_RESET;
      offset_z    = OFFSET_Z_RESET;
      error_count = 0;
    endfunction

    function void set_offset(cfg_reg_e idx, comp_t value);
      case (idx)
        REG_OFFSET_W: offset_w = value;
        REG_OFFSET_X: offset_x = value;
        REG_OFFSET_Y: offset_y = value;
        REG_OFFSET_Z: offset_z = value;
        default: ;
      endcase
    endfunction

    function wide_quat_t hamilton(wide_quat_t a, wide_quat_t b);
      wide_quat_t r;
      r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
      r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
      r.y = a.w * b.y + a.y * b.w + a.z * b.x - a.x * b.z;
      r.z = a.w * b.z + a.z * b.w + a.x * b.y - a.y * b.x;
      return r;
    endfunction

    // Round half up to FRAC_BITS fraction bits, keep the low output bits.
    function pose_comp_t round_component(longint v);
      longint shifted;
      shifted = (v + (longint'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      return shifted[OUT_WIDTH-1:0];
    endfunction

    function void note_orient(orient_t word);
      wide_quat_t q;
      wide_quat_t p;
      wide_quat_t qc;
      wide_quat_t r;
      pose_t      want;
      q.w  = longint'(word.orient_w);
      q.x  = longint'(word.orient_x);
      q.y  = longint'(word.orient_y);
      q.z  = longint'(word.orient_z);
      p.w  = longint'(offset_w);
      p.x  = longint'(offset_x);
      p.y  = longint'(offset_y);
      p.z  = longint'(offset_z);
      qc.w = q.w;
      qc.x = -q.x;
      qc.y = -q.y;
      qc.z = -q.z;
      r = hamilton(hamilton(q, p), qc);
      want.pose_w = round_component(r.w);
      want.pose_x = round_component(r.x);
      want.pose_y = round_component(r.y);
      want.pose_z = round_component(r.z);
      pending_poses.push_back(want);
    endfunction

    function void compare_field(string name, pose_comp_t want, pose_comp_t got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        error_count++;
      end
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        $error("pose word %h arrived with nothing pending", got);
        error_count++;
        return;
      end
      want = pending_poses.pop_front();
      compare_field("pose_w", want.pose_w, got.pose_w);
      compare_field("pose_x", want.pose_x, got.pose_x);
      compare_field("pose_y", want.pose_y, got.pose_y);
      compare_field("pose_z", want.pose_z, got.pose_z);
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  orient_t                   in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  pose_t                     out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i = '0;
  logic [COMP_WIDTH-1:0]     cfg_data_i  = '0;

  pose_scoreboard board = new();
  stall_mode_e    stall_mode = STALL_NONE;
  int             gap_max    = 0;
  bit             hold_req   = 1'b0;
  int             idle_cycles = 0;

  quaternion_sandwich_rotation_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Check every pose word taken at an edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_pose(out_data_o);
    end
  end

  // Stall the output on the current pattern; serve a long hold-off on request.
  initial begin
    int pattern_step;
    pattern_step = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pattern_step++;
        case (stall_mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall_i <= ((pattern_step % 8) < 3);
          default:        out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // End the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Pick a component: extremes, zero, rounding-tie magnitudes, small or full range.
  function automatic comp_t pick_component();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return ($urandom_range(0, 1) != 0) ? 16'sh0040 : 16'shffc0;
      4:       return comp_t'($urandom_range(0, 16)) - 16'sd8;
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic orient_t random_orient();
    orient_t word;
    word.orient_w = pick_component();
    word.orient_x = pick_component();
    word.orient_y = pick_component();
    word.orient_z = pick_component();
    return word;
  endfunction

  // Offer one orientation word and hold it until taken; valid stays high.
  task automatic push_orient(orient_t word);
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    board.note_orient(word);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Send random words in bursts, with random idle gaps between them when gap_max is nonzero.
  task automatic send_stream(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && left > 0) begin
        push_orient(random_orient());
        burst--;
        left--;
      end
      if (left > 0 && gap_max > 0) begin
        idle_gap($urandom_range(0, gap_max));
      end
    end
  endtask

  // Drop valid and wait until every pose word is back and the pipe is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one offset register; valid stays high for a following write.
  task automatic write_offset(cfg_reg_e idx, comp_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_offset(idx, value);
  endtask

  task automatic load_offsets(comp_t w, comp_t x, comp_t y, comp_t z);
    write_offset(REG_OFFSET_W, w);
    write_offset(REG_OFFSET_X, x);
    write_offset(REG_OFFSET_Y, y);
    write_offset(REG_OFFSET_Z, z);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset offsets.
    stall_mode = STALL_LIGHT;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      push_orient(DIRECTED_ORIENTS[i]);
      if (i < NUM_DIRECTED - 1) begin
        idle_gap($urandom_range(0, 2));
      end
    end
    idle_gap(1);
    send_stream(RANDOM_PER_PHASE);

    // Walk the offset sets, varying the traffic shape on each.
    for (phase = 0; phase < NUM_FIXED + NUM_RANDOM_SETS; phase++) begin
      drain();
      if (phase < NUM_FIXED) begin
        load_offsets(FIXED_OFFSETS[phase][0], FIXED_OFFSETS[phase][1],
                     FIXED_OFFSETS[phase][2], FIXED_OFFSETS[phase][3]);
      end else begin
        load_offsets(pick_component(), pick_component(), pick_component(),
                     pick_component());
      end
      stall_mode = stall_mode_e'(phase % 4);
      gap_max    = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 4 : 12);
      // Back up the pipe once with a long output hold-off.
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      send_stream(RANDOM_PER_PHASE);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.error_count == 0 && board.pending_poses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/qsr_pkg.sv
rtl/quaternion_sandwich_rotation_core.sv
dv/tb_top.sv
